/* src/polar_gaussian_pair_generator_defines.svh */
// assertion macros shared by the rtl
`ifndef POLAR_GAUSSIAN_PAIR_GENERATOR_DEFINES_SVH
`define POLAR_GAUSSIAN_PAIR_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define PGPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pgpg assertion failed");
// antecedent implies consequent in the next cycle
`define PGPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pgpg assertion failed");
`else
`define PGPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PGPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* src/pgpg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pgpg_pkg;

	localparam int UNIF_W = 31;
	localparam int OUT_W = 32;
	localparam int FRAC_BITS = 16;

	// 2 ln 2 in q.26
	localparam logic [26:0] TWO_LN2_Q26 = 27'd93032640;
	localparam logic [30:0] DEV_RESET = 31'(64'd1 << FRAC_BITS);
	localparam logic [14:0] LEN_RESET = 15'd100;

	typedef enum logic [1:0] {
		CFG_MEAN = 2'd0,
		CFG_DEV  = 2'd1,
		CFG_LEN  = 2'd2
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ_A,
		OP_SQ_B,
		OP_SUM,
		OP_NORM_INIT,
		OP_NORM_STEP,
		OP_LOG_INIT,
		OP_LOG_MUL,
		OP_LOG_ADJ,
		OP_NL,
		OP_L_LO,
		OP_L_HI,
		OP_SQRT_L_INIT,
		OP_SQRT_S_INIT,
		OP_SQRT_STEP,
		OP_MAG_MUL,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SCALE,
		OP_SAT,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   sel;
	} dp_cmd_t;

	typedef struct packed {
		logic reject;
		logic norm_done;
	} dp_status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ_A,
		ST_SQ_B,
		ST_SUM,
		ST_CHECK,
		ST_NORM,
		ST_LOG_MUL,
		ST_LOG_ADJ,
		ST_NL,
		ST_L_LO,
		ST_L_HI,
		ST_SQRT_L_INIT,
		ST_SQRT_L,
		ST_SQRT_S_INIT,
		ST_SQRT_S,
		ST_MAG_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_SCALE,
		ST_SAT,
		ST_EMIT
	} ctrl_state_t;

endpackage
`default_nettype wire

/* src/pgpg_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface pgpg_in_if import pgpg_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [UNIF_W-1:0] uniform_a;
	logic [UNIF_W-1:0] uniform_b;

	modport source (output valid, uniform_a, uniform_b, input ready);
	modport sink (input valid, uniform_a, uniform_b, output ready);
endinterface
`default_nettype wire

/* src/pgpg_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface pgpg_out_if import pgpg_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic                    accepted;
	logic signed [OUT_W-1:0] normal_a;
	logic signed [OUT_W-1:0] normal_b;
	logic                    last_pair;

	modport source (output valid, accepted, normal_a, normal_b, last_pair, input ready);
	modport sink (input valid, accepted, normal_a, normal_b, last_pair, output ready);
endinterface
`default_nettype wire

/* src/pgpg_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "polar_gaussian_pair_generator_defines.svh"
module pgpg_ctrl import pgpg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output dp_cmd_t         cmd,
	input  wire dp_status_t status
);

	ctrl_state_t state_q, state_d;
	logic [4:0]  cnt_q, cnt_d;
	logic        sel_q, sel_d;
	logic        out_valid_q;
	logic        emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		sel_d    = sel_q;
		cmd.op   = OP_NONE;
		cmd.sel  = sel_q;
		in_ready = 1'b0;
		emit     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_SQ_A;
				end
			end
			ST_SQ_A: begin
				cmd.op  = OP_SQ_A;
				state_d = ST_SQ_B;
			end
			ST_SQ_B: begin
				cmd.op  = OP_SQ_B;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.op  = OP_SUM;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.op  = OP_NORM_INIT;
				state_d = status.reject ? ST_EMIT : ST_NORM;
			end
			ST_NORM: begin
				if (status.norm_done) begin
					cmd.op  = OP_LOG_INIT;
					cnt_d   = '0;
					state_d = ST_LOG_MUL;
				end else begin
					cmd.op = OP_NORM_STEP;
				end
			end
			ST_LOG_MUL: begin
				cmd.op  = OP_LOG_MUL;
				state_d = ST_LOG_ADJ;
			end
			ST_LOG_ADJ: begin
				cmd.op = OP_LOG_ADJ;
				cnt_d  = cnt_q + 5'd1;
				// thirty fraction bits of log2
				state_d = (cnt_q == 5'd29) ? ST_NL : ST_LOG_MUL;
			end
			ST_NL: begin
				cmd.op  = OP_NL;
				state_d = ST_L_LO;
			end
			ST_L_LO: begin
				cmd.op  = OP_L_LO;
				state_d = ST_L_HI;
			end
			ST_L_HI: begin
				cmd.op  = OP_L_HI;
				state_d = ST_SQRT_L_INIT;
			end
			ST_SQRT_L_INIT: begin
				cmd.op  = OP_SQRT_L_INIT;
				cnt_d   = '0;
				state_d = ST_SQRT_L;
			end
			ST_SQRT_L: begin
				cmd.op  = OP_SQRT_STEP;
				cnt_d   = cnt_q + 5'd1;
				state_d = (cnt_q == 5'd31) ? ST_SQRT_S_INIT : ST_SQRT_L;
			end
			ST_SQRT_S_INIT: begin
				cmd.op  = OP_SQRT_S_INIT;
				cnt_d   = '0;
				state_d = ST_SQRT_S;
			end
			ST_SQRT_S: begin
				cmd.op = OP_SQRT_STEP;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					sel_d   = 1'b0;
					state_d = ST_MAG_MUL;
				end
			end
			ST_MAG_MUL: begin
				cmd.op  = OP_MAG_MUL;
				state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.op  = OP_DIV_INIT;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op  = OP_DIV_STEP;
				cnt_d   = cnt_q + 5'd1;
				state_d = (cnt_q == 5'd31) ? ST_SCALE : ST_DIV;
			end
			ST_SCALE: begin
				cmd.op  = OP_SCALE;
				state_d = ST_SAT;
			end
			ST_SAT: begin
				cmd.op = OP_SAT;
				if (sel_q) begin
					state_d = ST_EMIT;
				end else begin
					sel_d   = 1'b1;
					state_d = ST_MAG_MUL;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_EMIT;
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`PGPG_ASSERT_SAME(a_emit_slot_free, clk, arst_n, cmd.op == OP_EMIT, !out_valid_q || out_ready)
	`PGPG_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && in_ready, state_q == ST_SQ_A)
	`PGPG_ASSERT_NEXT(a_div_ends, clk, arst_n, state_q == ST_DIV && cnt_q == 5'd31, state_q == ST_SCALE)
	`PGPG_ASSERT_NEXT(a_emit_valid, clk, arst_n, emit, out_valid_q)

endmodule
`default_nettype wire

/* src/pgpg_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module pgpg_datapath import pgpg_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [31:0]             cfg_data,
	input  wire logic [UNIF_W-1:0]       uniform_a,
	input  wire logic [UNIF_W-1:0]       uniform_b,
	input  wire dp_cmd_t                 cmd,
	output dp_status_t                   status,
	output logic                         accepted,
	output logic signed [OUT_W-1:0]      normal_a,
	output logic signed [OUT_W-1:0]      normal_b,
	output logic                         last_pair
);

	// configuration
	logic signed [31:0] mean_q;
	logic [30:0]        dev_q;
	logic [14:0]        len_q;
	logic [13:0]        pairs_q;

	logic [30:0] ma_q, mb_q;
	logic        na_neg_q, nb_neg_q;
	logic [63:0] prod_q, acc_q;
	logic [61:0] s_q;
	logic [59:0] norm_q;
	logic [5:0]  shift_q;
	logic [30:0] m_q;
	logic [29:0] frac_q;
	logic [35:0] nl_q;
	logic [63:0] rad_q, res_q, bit_q;
	logic [31:0] q_q;
	logic [30:0] r_q;
	logic [31:0] rem_q, dnum_q, quo_q;
	logic [31:0] wa_q, wb_q;
	logic        out_acc_q, out_last_q;
	logic [31:0] out_a_q, out_b_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [31:0] log_t;
	logic [63:0] sq_trial;
	logic        sq_ge;
	logic [32:0] div_t, div_diff;
	logic        div_ge;
	logic [63:0] rnd;
	logic [36:0] mean_x, p_x, dev_v;
	logic [31:0] sat_v;
	logic        cur_neg;
	logic [13:0] target, cnt_next;
	logic        last_hit;

	assign status.reject    = (s_q == '0) || (s_q[61:60] != 2'b00);
	assign status.norm_done = norm_q[59];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ_A: begin
				mul_a = {1'b0, ma_q};
				mul_b = {1'b0, ma_q};
			end
			OP_SQ_B: begin
				mul_a = {1'b0, mb_q};
				mul_b = {1'b0, mb_q};
			end
			OP_LOG_MUL: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			OP_L_LO: begin
				mul_a = nl_q[31:0];
				mul_b = {5'd0, TWO_LN2_Q26};
			end
			OP_L_HI: begin
				mul_a = {28'd0, nl_q[35:32]};
				mul_b = {5'd0, TWO_LN2_Q26};
			end
			OP_MAG_MUL: begin
				mul_a = {1'b0, (cmd.sel ? mb_q : ma_q)};
				mul_b = q_q;
			end
			OP_SCALE: begin
				mul_a = {1'b0, dev_q};
				mul_b = quo_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// squaring step of the log2 fraction
	assign log_t = prod_q[61:30];

	// restoring square root, two radicand bits a step
	assign sq_trial = res_q + bit_q;
	assign sq_ge    = rad_q >= sq_trial;

	// restoring division, one quotient bit a step
	assign div_t    = {rem_q, dnum_q[31]};
	assign div_ge   = div_t >= {2'b00, r_q};
	assign div_diff = div_t - {2'b00, r_q};

	// round half away, apply sign and mean, saturate
	assign rnd     = prod_q + 64'h0000_0000_0800_0000;
	assign cur_neg = cmd.sel ? nb_neg_q : na_neg_q;
	assign mean_x  = {{5{mean_q[31]}}, mean_q};
	assign p_x     = {2'b00, rnd[62:28]};
	assign dev_v   = cur_neg ? (mean_x - p_x) : (mean_x + p_x);
	always_comb begin
		if (dev_v[36:31] == 6'b000000 || dev_v[36:31] == 6'b111111) begin
			sat_v = dev_v[31:0];
		end else if (dev_v[36]) begin
			sat_v = 32'h8000_0000;
		end else begin
			sat_v = 32'h7FFF_FFFF;
		end
	end

	// sequence pair count
	assign target   = (len_q[14:1] == '0) ? 14'd1 : len_q[14:1];
	assign cnt_next = pairs_q + 14'd1;
	assign last_hit = cnt_next >= target;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			dev_q  <= DEV_RESET;
			len_q  <= LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MEAN: mean_q <= cfg_data;
				CFG_DEV:  dev_q  <= cfg_data[30:0];
				CFG_LEN:  len_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q <= '0;
		end else if (cmd.op == OP_EMIT && !status.reject) begin
			pairs_q <= last_hit ? 14'd0 : cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				na_neg_q <= !uniform_a[30];
				nb_neg_q <= !uniform_b[30];
				ma_q <= uniform_a[30] ? {1'b0, uniform_a[29:0]}
					: (31'h4000_0000 - {1'b0, uniform_a[29:0]});
				mb_q <= uniform_b[30] ? {1'b0, uniform_b[29:0]}
					: (31'h4000_0000 - {1'b0, uniform_b[29:0]});
			end
			OP_SQ_A: prod_q <= mul_p;
			OP_SQ_B: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			OP_SUM: s_q <= acc_q[61:0] + prod_q[61:0];
			OP_NORM_INIT: begin
				norm_q  <= s_q[59:0];
				shift_q <= '0;
			end
			OP_NORM_STEP: begin
				if (norm_q[59:56] == 4'd0) begin
					norm_q  <= {norm_q[55:0], 4'd0};
					shift_q <= shift_q + 6'd4;
				end else begin
					norm_q  <= {norm_q[58:0], 1'b0};
					shift_q <= shift_q + 6'd1;
				end
			end
			OP_LOG_INIT: begin
				m_q    <= norm_q[59:29];
				frac_q <= '0;
			end
			OP_LOG_MUL: prod_q <= mul_p;
			OP_LOG_ADJ: begin
				m_q    <= log_t[31] ? log_t[31:1] : log_t[30:0];
				frac_q <= {frac_q[28:0], log_t[31]};
			end
			// -log2 s in q.30, integer part is shift + 1
			OP_NL: nl_q <= {shift_q + 6'd1, 30'd0} - {6'd0, frac_q};
			OP_L_LO: prod_q <= mul_p;
			OP_L_HI: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			OP_SQRT_L_INIT: begin
				rad_q <= acc_q + {prod_q[31:0], 32'd0};
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			OP_SQRT_S_INIT: begin
				q_q   <= res_q[31:0];
				rad_q <= {4'd0, s_q[59:0]};
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			OP_SQRT_STEP: begin
				if (sq_ge) begin
					rad_q <= rad_q - sq_trial;
					res_q <= {1'b0, res_q[63:1]} + bit_q;
				end else begin
					res_q <= {1'b0, res_q[63:1]};
				end
				bit_q <= {2'b00, bit_q[63:2]};
			end
			OP_MAG_MUL: begin
				r_q    <= res_q[30:0];
				prod_q <= mul_p;
			end
			OP_DIV_INIT: begin
				rem_q  <= prod_q[63:32];
				dnum_q <= prod_q[31:0];
				quo_q  <= '0;
			end
			OP_DIV_STEP: begin
				rem_q  <= div_ge ? div_diff[31:0] : div_t[31:0];
				quo_q  <= {quo_q[30:0], div_ge};
				dnum_q <= {dnum_q[30:0], 1'b0};
			end
			OP_SCALE: prod_q <= mul_p;
			OP_SAT: begin
				if (cmd.sel) begin
					wb_q <= sat_v;
				end else begin
					wa_q <= sat_v;
				end
			end
			OP_EMIT: begin
				out_acc_q  <= !status.reject;
				out_a_q    <= status.reject ? 32'd0 : wa_q;
				out_b_q    <= status.reject ? 32'd0 : wb_q;
				out_last_q <= !status.reject && last_hit;
			end
			default: ;
		endcase
	end

	assign accepted  = out_acc_q;
	assign normal_a  = out_a_q;
	assign normal_b  = out_b_q;
	assign last_pair = out_last_q;

endmodule
`default_nettype wire

/* src/polar_gaussian_pair_generator.sv */
// flow: a rejected pair goes from the check straight to its result, while the result of
// an accepted pair takes longer and varies with the normalize shift count
// throughput: one pair at a time; the 30 squaring steps of the log2 loop,
// two 32-step square roots and two 32-step divisions on the shared datapath set the rate
// reset: arst_n clears the controller, output valid and pair counter, loads config defaults
`timescale 1ns / 1ps
`default_nettype none
module polar_gaussian_pair_generator import pgpg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// uniform word pairs in, gaussian pairs out
	pgpg_in_if.sink          uniforms,
	pgpg_out_if.source       deviates
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer: walks square, normalize, log, sqrt, divide and scale steps
	pgpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (uniforms.valid),
		.in_ready  (uniforms.ready),
		.out_valid (deviates.valid),
		.out_ready (deviates.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// arithmetic: one shared 32x32 multiplier, sqrt and divider steps,
	// config registers, pair counter and the output register
	pgpg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.uniform_a (uniforms.uniform_a),
		.uniform_b (uniforms.uniform_b),
		.cmd       (cmd),
		.status    (status),
		.accepted  (deviates.accepted),
		.normal_a  (deviates.normal_a),
		.normal_b  (deviates.normal_b),
		.last_pair (deviates.last_pair)
	);

endmodule
`default_nettype wire
